@@ design/tsp_pkg.sv @@
// Shared constants and codes for the tabu-search tour optimizer.
package tsp_pkg;
    localparam int MAX_CITIES_DEF = 32;
    localparam int DIST_BITS_DEF  = 16;
    localparam int COST_BITS      = 21;
    localparam int STAMP_BITS     = COST_BITS + 1;
    localparam int IN_TDATA_W     = 40;
    localparam int OUT_TDATA_W    = 32;
    localparam int CFG_DATA_W     = 8;

    localparam logic [COST_BITS-1:0] COST_MAX = '1;

    typedef enum logic [1:0] {
        ACT_LOAD_DIST = 2'd0,
        ACT_LOAD_TOUR = 2'd1,
        ACT_START     = 2'd2,
        ACT_NONE      = 2'd3
    } action_t;

    typedef enum logic [0:0] {
        REG_NUM_CITIES  = 1'b0,
        REG_STALL_LIMIT = 1'b1
    } cfg_reg_t;
endpackage

@@ design/tsp_swap_tabu_search.sv @@
// Tabu-search tour optimizer over the swap neighborhood of a closed tour.
// A start clears all SDEPTH entries of the tabu store (MAX_CITIES-1 rounded up to a power of two,
// squared), walks the start tour, then runs passes over the position pairs i, j < len, len =
// num_cities-1, skipping i == j and tabu pairs; passes repeat while one improves. Results leave
// one slot at a time, each held until taken. Reset (aresetn low, synchronous) idles the block,
// loads 32 and 32.
module tsp_swap_tabu_search #(
    parameter int MAX_CITIES = tsp_pkg::MAX_CITIES_DEF,
    parameter int DIST_BITS  = tsp_pkg::DIST_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // from_city[4:0], to_city[9:5], distance[25:10], tour_slot[30:26],
    // tour_city[35:31], zero pad
    input  logic [tsp_pkg::IN_TDATA_W-1:0]    s_tdata,
    // action[1:0]
    input  logic [1:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // slot[4:0], city[9:5], tour_cost[30:10], zero pad
    output logic [tsp_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic                              m_tlast,
    input  logic                              cfg_wr_en,
    input  logic [0:0]                        cfg_index,
    input  logic [tsp_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import tsp_pkg::*;

    localparam int CW      = $clog2(MAX_CITIES);
    localparam int PW      = $clog2(MAX_CITIES - 1);
    localparam int NW      = $clog2(MAX_CITIES + 1);
    localparam int TDEPTH  = MAX_CITIES - 1;
    localparam int DDEPTH  = 1 << (2 * CW);
    localparam int SDEPTH  = 1 << (2 * PW);
    localparam int SW      = ((DIST_BITS > COST_BITS) ? DIST_BITS : COST_BITS) + 1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CLEAR, ST_WALK, ST_WALK_END, ST_DECIDE, ST_PAIR, ST_TABU_CHK,
        ST_SWAP_A, ST_SWAP_B, ST_NEXT, ST_PASS_END, ST_EMIT_LOAD, ST_EMIT_WAIT
    } state_t;

    state_t state_reg;

    // Configuration
    logic [5:0] num_cities_reg;
    logic [7:0] stall_limit_reg;

    // Storage
    logic [DIST_BITS-1:0]  dist_mem [DDEPTH];
    logic [DIST_BITS-1:0]  dist_q_reg;
    logic [STAMP_BITS:0]   stamp_mem [SDEPTH];
    logic [STAMP_BITS:0]   stamp_q_reg;
    logic [4:0]            cur_tour_reg [TDEPTH];
    logic [4:0]            best_tour_reg [TDEPTH];

    // Search control
    logic [2*PW-1:0]       clr_idx_reg;
    logic [PW-1:0]         i_reg, j_reg;
    logic [CW-1:0]         k_reg;
    logic [4:0]            prev_city_reg;
    logic [4:0]            tmp_city_reg;
    logic                  swap_en_reg;
    logic                  init_reg;
    logic                  improved_reg;
    logic [STAMP_BITS-1:0] imp_cnt_reg;
    logic [COST_BITS-1:0]  sum_reg;
    logic [COST_BITS-1:0]  best_cost_reg;
    logic                  acc_vld_reg;
    logic                  acc_oor_reg;

    // Output stage
    logic [PW-1:0]         slot_reg;
    logic                  m_tvalid_reg;
    logic [4:0]            out_slot_reg;
    logic [4:0]            out_city_reg;
    logic                  out_last_reg;

    // Input fields
    logic [1:0]  in_action;
    logic [4:0]  in_from, in_to, in_slot, in_city;
    logic [15:0] in_dist;
    logic        in_acc;
    assign in_action = s_tuser;
    assign in_from   = s_tdata[4:0];
    assign in_to     = s_tdata[9:5];
    assign in_dist   = s_tdata[25:10];
    assign in_slot   = s_tdata[30:26];
    assign in_city   = s_tdata[35:31];
    assign in_acc    = s_tvalid && s_tready;

    // Effective city count, saturated into 3..MAX_CITIES
    logic [6:0]    nc_ext;
    logic [NW-1:0] n_sat;
    logic [CW-1:0] len;
    logic [PW-1:0] len_m1;
    assign nc_ext = {1'b0, num_cities_reg};
    always_comb begin
        if (nc_ext < 7'd3) begin
            n_sat = NW'(3);
        end else if (nc_ext > 7'(MAX_CITIES)) begin
            n_sat = NW'(MAX_CITIES);
        end else begin
            n_sat = NW'(nc_ext);
        end
    end
    assign len    = CW'(n_sat - NW'(1));
    assign len_m1 = PW'(n_sat - NW'(2));

    // Load decode
    logic [5:0] from6, to6, slot6;
    logic       dist_we, tour_we;
    assign from6   = {1'b0, in_from};
    assign to6     = {1'b0, in_to};
    assign slot6   = {1'b0, in_slot};
    assign dist_we = in_acc && (in_action == ACT_LOAD_DIST)
                     && ({1'b0, from6} < 7'(MAX_CITIES)) && ({1'b0, to6} < 7'(MAX_CITIES));
    assign tour_we = in_acc && (in_action == ACT_LOAD_TOUR)
                     && ({1'b0, slot6} < 7'(MAX_CITIES - 1));

    // Cost walk: position k of the tour with positions i and j exchanged
    logic [PW-1:0] k_pos, walk_pos;
    logic [4:0]    walk_city;
    logic [5:0]    walk6, prev6;
    logic          walk_oor, prev_oor;
    assign k_pos = k_reg[PW-1:0];
    always_comb begin
        if (swap_en_reg && (k_pos == i_reg)) begin
            walk_pos = j_reg;
        end else if (swap_en_reg && (k_pos == j_reg)) begin
            walk_pos = i_reg;
        end else begin
            walk_pos = k_pos;
        end
    end
    assign walk_city = (k_reg == len) ? 5'd0 : cur_tour_reg[walk_pos];
    assign walk6     = {1'b0, walk_city};
    assign prev6     = {1'b0, prev_city_reg};
    assign walk_oor  = {1'b0, walk6} >= 7'(MAX_CITIES);
    assign prev_oor  = {1'b0, prev6} >= 7'(MAX_CITIES);

    logic [2*CW-1:0] dist_ra, dist_wa;
    assign dist_ra = {prev6[CW-1:0], walk6[CW-1:0]};
    assign dist_wa = {from6[CW-1:0], to6[CW-1:0]};

    // Saturating accumulate of the distance returned from memory
    logic [SW-1:0]        sum_ext;
    logic [COST_BITS-1:0] sum_sat;
    assign sum_ext = SW'(sum_reg) + (acc_oor_reg ? SW'(0) : SW'(dist_q_reg));
    assign sum_sat = (sum_ext > SW'(COST_MAX)) ? COST_MAX : sum_ext[COST_BITS-1:0];

    // Tabu stamp store: entry holds valid and the improvement count at marking
    logic [PW-1:0]         hi_pos, lo_pos;
    logic [2*PW-1:0]       pair_idx, stamp_wa;
    logic                  stamp_we;
    logic [STAMP_BITS:0]   stamp_wd;
    logic [STAMP_BITS-1:0] stamp_age;
    logic                  is_tabu;
    assign hi_pos    = (i_reg > j_reg) ? i_reg : j_reg;
    assign lo_pos    = (i_reg > j_reg) ? j_reg : i_reg;
    assign pair_idx  = {hi_pos, lo_pos};
    assign stamp_we  = (state_reg == ST_CLEAR) || (state_reg == ST_SWAP_B);
    assign stamp_wa  = (state_reg == ST_CLEAR) ? clr_idx_reg : pair_idx;
    assign stamp_wd  = (state_reg == ST_CLEAR) ? '0 : {1'b1, imp_cnt_reg + 1'b1};
    assign stamp_age = imp_cnt_reg - stamp_q_reg[STAMP_BITS-1:0];
    assign is_tabu   = stamp_q_reg[STAMP_BITS] && (stamp_age < STAMP_BITS'(n_sat));

    always_ff @(posedge aclk) begin
        if (dist_we) begin
            dist_mem[dist_wa] <= DIST_BITS'(in_dist);
        end
        dist_q_reg <= dist_mem[dist_ra];
    end

    always_ff @(posedge aclk) begin
        if (stamp_we) begin
            stamp_mem[stamp_wa] <= stamp_wd;
        end
        stamp_q_reg <= stamp_mem[pair_idx];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            num_cities_reg  <= 6'd32;
            stall_limit_reg <= 8'd32;
            best_cost_reg   <= '0;
            m_tvalid_reg    <= 1'b0;
            acc_vld_reg     <= 1'b0;
            init_reg        <= 1'b0;
            improved_reg    <= 1'b0;
            swap_en_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_NUM_CITIES:  num_cities_reg  <= cfg_data[5:0];
                    REG_STALL_LIMIT: stall_limit_reg <= cfg_data;
                    default:         ;
                endcase
            end
            if (tour_we) begin
                cur_tour_reg[slot6[PW-1:0]] <= in_city;
            end
            acc_vld_reg <= (state_reg == ST_WALK);
            if (acc_vld_reg) begin
                sum_reg <= sum_sat;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (in_acc && (in_action == ACT_START)) begin
                        clr_idx_reg <= '0;
                        imp_cnt_reg <= '0;
                        init_reg    <= 1'b1;
                        state_reg   <= ST_CLEAR;
                    end
                end
                ST_CLEAR: begin
                    clr_idx_reg <= clr_idx_reg + 1'b1;
                    if (clr_idx_reg == '1) begin
                        k_reg         <= '0;
                        prev_city_reg <= '0;
                        sum_reg       <= '0;
                        swap_en_reg   <= 1'b0;
                        state_reg     <= ST_WALK;
                    end
                end
                ST_WALK: begin
                    prev_city_reg <= walk_city;
                    acc_oor_reg   <= prev_oor || walk_oor;
                    k_reg         <= k_reg + 1'b1;
                    if (k_reg == len) begin
                        state_reg <= ST_WALK_END;
                    end
                end
                ST_WALK_END: begin
                    state_reg <= ST_DECIDE;
                end
                ST_DECIDE: begin
                    if (init_reg) begin
                        init_reg      <= 1'b0;
                        best_cost_reg <= sum_reg;
                        best_tour_reg <= cur_tour_reg;
                        i_reg         <= '0;
                        j_reg         <= '0;
                        improved_reg  <= 1'b0;
                        slot_reg      <= '0;
                        state_reg     <= (stall_limit_reg == 8'd0) ? ST_EMIT_LOAD : ST_PAIR;
                    end else if (sum_reg < best_cost_reg) begin
                        state_reg <= ST_SWAP_A;
                    end else begin
                        state_reg <= ST_NEXT;
                    end
                end
                ST_PAIR: begin
                    state_reg <= (i_reg == j_reg) ? ST_NEXT : ST_TABU_CHK;
                end
                ST_TABU_CHK: begin
                    if (is_tabu) begin
                        state_reg <= ST_NEXT;
                    end else begin
                        k_reg         <= '0;
                        prev_city_reg <= '0;
                        sum_reg       <= '0;
                        swap_en_reg   <= 1'b1;
                        state_reg     <= ST_WALK;
                    end
                end
                ST_SWAP_A: begin
                    tmp_city_reg <= cur_tour_reg[i_reg];
                    state_reg    <= ST_SWAP_B;
                end
                ST_SWAP_B: begin
                    cur_tour_reg[i_reg] <= cur_tour_reg[j_reg];
                    cur_tour_reg[j_reg] <= tmp_city_reg;
                    imp_cnt_reg         <= imp_cnt_reg + 1'b1;
                    best_cost_reg       <= sum_reg;
                    improved_reg        <= 1'b1;
                    state_reg           <= ST_NEXT;
                end
                ST_NEXT: begin
                    if (j_reg == len_m1) begin
                        j_reg <= '0;
                        if (i_reg == len_m1) begin
                            state_reg <= ST_PASS_END;
                        end else begin
                            i_reg     <= i_reg + 1'b1;
                            state_reg <= ST_PAIR;
                        end
                    end else begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= ST_PAIR;
                    end
                end
                ST_PASS_END: begin
                    // an improving pass saves the tour and starts another; a quiet one
                    // would repeat itself, so stop at once
                    i_reg <= '0;
                    j_reg <= '0;
                    if (improved_reg) begin
                        best_tour_reg <= cur_tour_reg;
                        improved_reg  <= 1'b0;
                        state_reg     <= ST_PAIR;
                    end else begin
                        slot_reg  <= '0;
                        state_reg <= ST_EMIT_LOAD;
                    end
                end
                ST_EMIT_LOAD: begin
                    out_slot_reg <= 5'(slot_reg);
                    out_city_reg <= best_tour_reg[slot_reg];
                    out_last_reg <= (slot_reg == len_m1);
                    m_tvalid_reg <= 1'b1;
                    state_reg    <= ST_EMIT_WAIT;
                end
                ST_EMIT_WAIT: begin
                    if (m_tready) begin
                        m_tvalid_reg <= 1'b0;
                        if (out_last_reg) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            slot_reg  <= slot_reg + 1'b1;
                            state_reg <= ST_EMIT_LOAD;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {1'b0, best_cost_reg, out_city_reg, out_slot_reg};

    // A start transaction drops ready on the next cycle.
    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == ACT_START)) |=> !s_tready)
        else $error("ready held after start");

    // The cost walk never runs past the closing return home.
    a_walk_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK) |-> (k_reg <= len))
        else $error("cost walk overran tour");

    // A result is never offered while input is taken.
    a_out_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("result and input overlap");

    // The final result carries the last tour position.
    a_last_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (out_slot_reg == 5'(len_m1)))
        else $error("last flag on wrong slot");
endmodule
